>>> hw/rtl/rdc_pkg.sv
// Shared types, codes and constants of the register-programmed DMA copier.
// No dependencies; every module imports this package.
package rdc_pkg;

    localparam int WORD_BYTES = 4;
    localparam int ADDR_WIDTH = 32;

    localparam logic [31:0] ADDR_MASK = (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF
                                        : 32'((64'd1 << ADDR_WIDTH) - 64'd1);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [15:0] REG_SRC = 16'd0;
    localparam logic [15:0] REG_DST = 16'd4;
    localparam logic [15:0] REG_LEN = 16'd8;
    localparam logic [15:0] REG_CTL = 16'd12;

    localparam logic [3:0] CTL_BE = 4'b0001;

    typedef enum logic [1:0] {
        OP_REG_WRITE = 2'd0,
        OP_REG_READ  = 2'd1,
        OP_MEM_DATA  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_REG  = 2'd0,
        KIND_RD   = 2'd1,
        KIND_WR   = 2'd2,
        KIND_DONE = 2'd3
    } t_kind;

    // data is read data for a register response, write data for a write request
    typedef struct packed {
        t_kind       kind;
        logic        ok;
        logic [31:0] data;
        logic [31:0] base;
        logic [31:0] off;
        logic        irq;
    } t_result;

    typedef struct packed {
        t_result r0;
        t_result r1;
        logic    two;
    } t_entry;

    function automatic t_result mk_result(t_kind kind, logic ok, logic [31:0] data,
                                          logic [31:0] base, logic [31:0] off,
                                          logic irq);
        t_result r;
        r.kind = kind;
        r.ok   = ok;
        r.data = data;
        r.base = base;
        r.off  = off;
        r.irq  = irq;
        return r;
    endfunction

endpackage

>>> hw/rtl/rdc_in_if.sv
// Request channel of the DMA copier: bus accesses and returned memory words.
// Plain valid/ready interface, no dependencies.
interface rdc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] reg_offset;
    logic [3:0]  lane_en;
    logic [31:0] write_data;
    logic [31:0] mem_read_data;
    logic        mem_read_error;

    modport source (output valid, opcode, reg_offset, lane_en, write_data,
                    mem_read_data, mem_read_error, input ready);
    modport sink   (input valid, opcode, reg_offset, lane_en, write_data,
                    mem_read_data, mem_read_error, output ready);
endinterface

>>> hw/rtl/rdc_out_if.sv
// Response channel of the DMA copier: register responses and memory requests.
// Plain valid/ready interface, no dependencies.
interface rdc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        access_ok;
    logic [31:0] read_data;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
    logic        irq_level;
    logic        last;

    modport source (output valid, kind, access_ok, read_data, mem_address,
                    mem_write_data, irq_level, last, input ready);
    modport sink   (input valid, kind, access_ok, read_data, mem_address,
                    mem_write_data, irq_level, last, output ready);
endinterface

>>> hw/rtl/rdc_front.sv
// Front end: accepts requests, owns the register file and copy state, and turns
// each request but stray memory data into a one- or two-result entry. Uses rdc_pkg.
module rdc_front import rdc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_we,
    input  logic   i_cfg_wdata,
    rdc_in_if.sink i_req,
    input  logic   i_q_full,
    output logic   o_push,
    output t_entry o_entry
);

    logic        r_big, n_big;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [31:0] r_len, n_len;
    logic [31:0] r_off, n_off;
    logic        r_start, n_start;
    logic        r_irq, n_irq;

    logic        accept;
    logic [7:0]  ctl_byte;
    logic [7:0]  ctl_wbyte;
    logic [32:0] off_sum;
    logic [31:0] off_inc;
    logic        ok;

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && i_req.ready;

    assign ctl_byte  = {3'b000, r_irq, 3'b000, r_start};
    assign ctl_wbyte = r_big ? i_req.write_data[31:24] : i_req.write_data[7:0];

    // saturate so the end test never sees a wrapped offset
    assign off_sum = {1'b0, r_off} + 33'(WORD_BYTES);
    assign off_inc = off_sum[32] ? 32'hFFFF_FFFF : off_sum[31:0];

    always_comb begin
        n_big   = i_cfg_we ? i_cfg_wdata : r_big;
        n_src   = r_src;
        n_dst   = r_dst;
        n_len   = r_len;
        n_off   = r_off;
        n_start = r_start;
        n_irq   = r_irq;
        ok      = 1'b1;
        o_push  = 1'b0;
        o_entry = '0;
        if (accept) begin
            unique case (i_req.opcode)
                OP_REG_WRITE: begin
                    o_push = 1'b1;
                    priority if (i_req.reg_offset == REG_SRC) begin
                        n_src = i_req.write_data;
                    end else if (i_req.reg_offset == REG_DST) begin
                        n_dst = i_req.write_data;
                    end else if (i_req.reg_offset == REG_LEN) begin
                        n_len = i_req.write_data;
                    end else if (i_req.reg_offset == REG_CTL &&
                                 i_req.lane_en == CTL_BE) begin
                        if (ctl_wbyte[0] && !r_start) begin
                            n_start     = 1'b1;
                            n_off       = '0;
                            o_entry.two = 1'b1;
                        end
                        if (!ctl_wbyte[4]) begin
                            n_irq = 1'b0;
                        end
                    end else begin
                        ok = 1'b0;
                    end
                    o_entry.r0 = mk_result(KIND_REG, ok, '0, '0, '0, n_irq);
                    if (o_entry.two) begin
                        // zero length: finish at once on an empty transfer
                        if (r_len == '0) begin
                            n_start    = 1'b0;
                            n_irq      = 1'b1;
                            o_entry.r1 = mk_result(KIND_DONE, 1'b0, '0, '0, '0, 1'b1);
                        end else begin
                            o_entry.r1 = mk_result(KIND_RD, 1'b0, '0, r_src, '0, n_irq);
                        end
                    end
                end
                OP_REG_READ: begin
                    o_push = 1'b1;
                    priority if (i_req.reg_offset == REG_SRC) begin
                        o_entry.r0 = mk_result(KIND_REG, 1'b1, r_src, '0, '0, r_irq);
                    end else if (i_req.reg_offset == REG_DST) begin
                        o_entry.r0 = mk_result(KIND_REG, 1'b1, r_dst, '0, '0, r_irq);
                    end else if (i_req.reg_offset == REG_LEN) begin
                        o_entry.r0 = mk_result(KIND_REG, 1'b1, r_len, '0, '0, r_irq);
                    end else if (i_req.reg_offset == REG_CTL &&
                                 i_req.lane_en == CTL_BE) begin
                        o_entry.r0 = mk_result(KIND_REG, 1'b1,
                                               r_big ? {ctl_byte, 24'd0} : {24'd0, ctl_byte},
                                               '0, '0, r_irq);
                    end else begin
                        o_entry.r0 = mk_result(KIND_REG, 1'b0, '0, '0, '0, r_irq);
                    end
                end
                OP_MEM_DATA: begin
                    // drop stray data when no transfer runs
                    if (r_start) begin
                        t_result adv;
                        o_push = 1'b1;
                        n_off  = off_inc;
                        if (off_inc >= r_len) begin
                            n_start = 1'b0;
                            n_irq   = 1'b1;
                            adv     = mk_result(KIND_DONE, 1'b0, '0, '0, '0, 1'b1);
                        end else begin
                            adv = mk_result(KIND_RD, 1'b0, '0, r_src, off_inc, r_irq);
                        end
                        if (!i_req.mem_read_error) begin
                            o_entry.r0  = mk_result(KIND_WR, 1'b0, i_req.mem_read_data,
                                                    r_dst, r_off, r_irq);
                            o_entry.r1  = adv;
                            o_entry.two = 1'b1;
                        end else begin
                            o_entry.r0 = adv;
                        end
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big   <= 1'b0;
            r_src   <= '0;
            r_dst   <= '0;
            r_len   <= '0;
            r_off   <= '0;
            r_start <= 1'b0;
            r_irq   <= 1'b0;
        end else begin
            r_big   <= n_big;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_len   <= n_len;
            r_off   <= n_off;
            r_start <= n_start;
            r_irq   <= n_irq;
        end
    end

endmodule

>>> hw/rtl/rdc_queue.sv
// Short FIFO of result entries between front and back ends.
// Register based, QDEPTH entries from rdc_pkg.
module rdc_queue import rdc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_nonempty,
    output t_entry o_head
);

    t_entry         r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QAW:0]   r_count, n_count;
    logic           do_pop;

    assign o_full     = (r_count == (QAW+1)'(QDEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rp];
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wp    = i_push ? QAW'(r_wp + 1'b1) : r_wp;
        n_rp    = do_pop ? QAW'(r_rp + 1'b1) : r_rp;
        n_count = r_count + (QAW+1)'(i_push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full result queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("result queue count out of range");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !do_pop)
        else $error("pop from empty result queue");

endmodule

>>> hw/rtl/rdc_back.sv
// Back end: plays the head queue entry out as one or two responses,
// forming addresses and zeroing unused fields. Uses rdc_pkg.
module rdc_back import rdc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_nonempty,
    input  t_entry       i_head,
    output logic         o_pop,
    rdc_out_if.source    o_rsp
);

    logic    r_sel, n_sel;
    t_result cur;
    logic    last;
    logic    fire;

    assign cur  = r_sel ? i_head.r1 : i_head.r0;
    assign last = r_sel || !i_head.two;
    assign fire = o_rsp.valid && o_rsp.ready;

    assign o_rsp.valid          = i_nonempty;
    assign o_rsp.kind           = cur.kind;
    assign o_rsp.access_ok      = cur.ok;
    assign o_rsp.read_data      = (cur.kind == KIND_REG) ? cur.data : '0;
    assign o_rsp.mem_write_data = (cur.kind == KIND_WR) ? cur.data : '0;
    assign o_rsp.mem_address    = (cur.base + cur.off) & ADDR_MASK;
    assign o_rsp.irq_level      = cur.irq;
    assign o_rsp.last           = last;

    // release the entry after its final response
    assign o_pop = fire && last;

    always_comb begin
        n_sel = r_sel;
        if (fire) begin
            n_sel = !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else begin
            r_sel <= n_sel;
        end
    end

    a_second_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && r_sel) |-> (cur.kind == KIND_RD || cur.kind == KIND_DONE))
        else $error("second response of an entry is not a read request or done");

    a_sel_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !last) |=> (r_sel && o_rsp.valid))
        else $error("second response lost after first was taken");

    a_sel_only_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (i_nonempty && i_head.two))
        else $error("second-half select without a two-result entry");

endmodule

>>> hw/rtl/register_programmed_dma_copier.sv
// Channel    Dir  Handshake          Payload
// i_req      in   valid/ready        opcode, reg_offset, lane_en, write/mem data, error
// o_rsp      out  valid/ready        kind, access_ok, read_data, mem_address, write data, irq
// cfg        in   i_cfg_we           i_cfg_wdata (big endian control byte)
//
// A request is taken every cycle while the result queue has room; its one or
// two results leave one per cycle while o_rsp is ready, so single-result requests
// sustain one per cycle and a two-result request holds the back end for both responses.
// Each entry is written into the queue registers between acceptance and its first response.
// The four-entry result queue lets the request side run on while the response
// side is stalled. Synchronous active-low reset clears the registers and the
// queue pointers; queue storage is left as it is.
module register_programmed_dma_copier import rdc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    rdc_in_if.sink     i_req,
    rdc_out_if.source  o_rsp
);

    logic   push;
    t_entry entry;
    logic   q_full;
    logic   q_nonempty;
    t_entry head;
    logic   pop;

    rdc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_entry     (entry)
    );

    rdc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (entry),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head)
    );

    rdc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (q_nonempty),
        .i_head     (head),
        .o_pop      (pop),
        .o_rsp      (o_rsp)
    );

endmodule
